[rtl/core/cmfs_pkg.sv]
// ----------------------------------------------------------------------------
// Cube map face select package
// Shared widths, codes and payload types of the cube map face selector.
// ----------------------------------------------------------------------------
`default_nettype none

package cmfs_pkg;

   localparam int COORD_BITS    = 16;
   localparam int MAG_BITS      = COORD_BITS;
   localparam int SUM_BITS      = COORD_BITS + 1;
   localparam int SIZE_BITS     = 13;
   localparam int IDX_BITS      = 12;
   localparam int NUM_BITS      = SUM_BITS + IDX_BITS;
   localparam int FACE_BITS     = 3;
   localparam int MAX_FACE_SIZE = 4096;
   localparam int CSR_ADDR_BITS = 1;

   localparam logic [FACE_BITS-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_BITS-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_BITS-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_BITS-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_BITS-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_BITS-1:0] FACE_NEG_Z = 3'd5;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_FACE_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FACE_HEIGHT = 1'b1;

   localparam logic [SIZE_BITS-1:0] FACE_SIZE_RESET = 13'd512;

   typedef struct packed {
      logic                 valid;
      logic [FACE_BITS-1:0] face;
      logic                 zero;
      logic [NUM_BITS-1:0]  rem_u;
      logic [NUM_BITS-1:0]  rem_v;
      logic [IDX_BITS-1:0]  q_u;
      logic [IDX_BITS-1:0]  q_v;
      logic [SUM_BITS-1:0]  den;
   } div_stage_type;

   typedef struct packed {
      logic [FACE_BITS-1:0] face;
      logic [IDX_BITS-1:0]  texel_col;
      logic [IDX_BITS-1:0]  texel_row;
      logic                 zero_vector;
   } rsp_data_type;

   function automatic logic [MAG_BITS-1:0] mag_of(input logic signed [COORD_BITS-1:0] a);
      logic [MAG_BITS-1:0] r;
      r = a[COORD_BITS-1] ? MAG_BITS'(~a + 1'b1) : MAG_BITS'(a);
      return r;
   endfunction

   function automatic logic [IDX_BITS-1:0] size_to_scale(input logic [SIZE_BITS-1:0] s);
      logic [IDX_BITS-1:0] r;
      if (s == '0) begin
         r = '0;
      end else if (s > SIZE_BITS'(MAX_FACE_SIZE)) begin
         r = IDX_BITS'(MAX_FACE_SIZE - 1);
      end else begin
         r = IDX_BITS'(s - 1'b1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/core/cmfs_if.sv]
// ----------------------------------------------------------------------------
// Cube map face select channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface cmfs_req_if;
   import cmfs_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] dir_x;
   logic signed [COORD_BITS-1:0] dir_y;
   logic signed [COORD_BITS-1:0] dir_z;
   modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
   modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cmfs_rsp_if;
   import cmfs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [FACE_BITS-1:0] face;
   logic [IDX_BITS-1:0]  texel_col;
   logic [IDX_BITS-1:0]  texel_row;
   logic                 zero_vector;
   modport source (output valid, output face, output texel_col, output texel_row,
                   output zero_vector, input ready);
   modport sink (input valid, input face, input texel_col, input texel_row,
                 input zero_vector, output ready);
endinterface

`default_nettype wire

[rtl/core/cube_map_face_texel_select.sv]
// ----------------------------------------------------------------------------
// Cube map face and texel select
// Picks the cube face hit by a direction vector and the texel within it.
// ----------------------------------------------------------------------------
// Each request item carries a signed direction (dir_x, dir_y, dir_z). Each
// response item carries the face code, the texel column and row, and a flag
// that is set, with all other fields zero, for an all-zero direction.
// The user must write the face size registers through the csr port only
// while the block is idle; the block does not enforce this. Sizes of zero
// read as one and sizes above 4096 read as 4096. An item is accepted when
// valid and ready are both high. Its result passes through four stages of
// face selection and scaling, twelve divider stages that each resolve one
// bit of both texel indices, and the output register. One item enters per
// cycle while req.ready is high. When the receiver stalls, the next item out
// of the pipeline is held in a skid register and the pipeline then freezes,
// so req.ready follows a register and no item is lost or repeated. Reset
// empties the pipeline and sets both face sizes to 512.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_map_face_texel_select (
   input  wire logic                               clock,
   input  wire logic                               reset,
   cmfs_req_if.sink                                req,
   cmfs_rsp_if.source                              rsp,
   input  wire logic                               csr_we,
   input  wire logic [cmfs_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [cmfs_pkg::SIZE_BITS-1:0]     csr_wdata
);
   import cmfs_pkg::*;

   logic [SIZE_BITS-1:0] width_ff, height_ff;
   logic [IDX_BITS-1:0]  scale_u, scale_v;

   logic          en;
   div_stage_type front_stage, last_stage;
   rsp_data_type  last_data;
   logic          push;

   logic          out_valid_ff, out_valid_in;
   rsp_data_type  out_data_ff, out_data_in;
   logic          skid_valid_ff, skid_valid_in;
   rsp_data_type  skid_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FACE_SIZE_RESET;
         height_ff <= FACE_SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_FACE_WIDTH:  width_ff  <= csr_wdata;
            CSR_FACE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign scale_u = size_to_scale(width_ff);
   assign scale_v = size_to_scale(height_ff);

   assign en        = !skid_valid_ff;
   assign req.ready = en;

   cmfs_select u_select (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req.valid),
      .dir_x     (req.dir_x),
      .dir_y     (req.dir_y),
      .dir_z     (req.dir_z),
      .scale_u   (scale_u),
      .scale_v   (scale_v),
      .out_stage (front_stage)
   );

   cmfs_div_pipe u_div_pipe (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_stage  (front_stage),
      .out_stage (last_stage)
   );

   always_comb begin
      last_data.face        = last_stage.zero ? FACE_POS_X : last_stage.face;
      last_data.texel_col   = last_stage.zero ? '0 : last_stage.q_u;
      last_data.texel_row   = last_stage.zero ? '0 : last_stage.q_v;
      last_data.zero_vector = last_stage.zero;
      push = en && last_stage.valid;
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp.ready) begin
         out_valid_in  = skid_valid_ff || push;
         out_data_in   = skid_valid_ff ? skid_data_ff : last_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      if (push) begin
         skid_data_ff <= last_data;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.face        = out_data_ff.face;
   assign rsp.texel_col   = out_data_ff.texel_col;
   assign rsp.texel_row   = out_data_ff.texel_row;
   assign rsp.zero_vector = out_data_ff.zero_vector;

endmodule

`default_nettype wire

[rtl/core/cmfs_select.sv]
// ----------------------------------------------------------------------------
// Cube map face select front end
// Registers the direction, picks the face and face coordinates, offsets them
// and scales them by the face size to form the dividends.
// ----------------------------------------------------------------------------
`default_nettype none

module cmfs_select (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 en,
   input  wire logic                                 in_valid,
   input  wire logic signed [cmfs_pkg::COORD_BITS-1:0] dir_x,
   input  wire logic signed [cmfs_pkg::COORD_BITS-1:0] dir_y,
   input  wire logic signed [cmfs_pkg::COORD_BITS-1:0] dir_z,
   input  wire logic [cmfs_pkg::IDX_BITS-1:0]        scale_u,
   input  wire logic [cmfs_pkg::IDX_BITS-1:0]        scale_v,
   output cmfs_pkg::div_stage_type                   out_stage
);
   import cmfs_pkg::*;

   logic                         s1_valid_ff;
   logic signed [COORD_BITS-1:0] s1_x_ff, s1_y_ff, s1_z_ff;

   logic                         s2_valid_ff;
   logic [FACE_BITS-1:0]         s2_face_ff, s2_face_in;
   logic                         s2_zero_ff, s2_zero_in;
   logic signed [SUM_BITS-1:0]   s2_uc_ff, s2_uc_in, s2_vc_ff, s2_vc_in;
   logic [MAG_BITS-1:0]          s2_m_ff, s2_m_in;

   logic                         s3_valid_ff;
   logic [FACE_BITS-1:0]         s3_face_ff;
   logic                         s3_zero_ff;
   logic [SUM_BITS-1:0]          s3_cu_ff, s3_cu_in, s3_cv_ff, s3_cv_in, s3_den_ff, s3_den_in;

   div_stage_type                s4_ff, s4_in;

   logic [MAG_BITS-1:0]          ax, ay, az;
   logic signed [SUM_BITS-1:0]   ex, ey, ez;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_ff.valid <= s3_valid_ff;
      end
   end

   always_comb begin
      ax = mag_of(s1_x_ff);
      ay = mag_of(s1_y_ff);
      az = mag_of(s1_z_ff);
      ex = SUM_BITS'(s1_x_ff);
      ey = SUM_BITS'(s1_y_ff);
      ez = SUM_BITS'(s1_z_ff);
      s2_zero_in = (ax == '0) && (ay == '0) && (az == '0);
      if ((ax >= ay) && (ax >= az)) begin
         s2_m_in    = ax;
         s2_uc_in   = s1_x_ff[COORD_BITS-1] ? ez : -ez;
         s2_vc_in   = ey;
         s2_face_in = s1_x_ff[COORD_BITS-1] ? FACE_NEG_X : FACE_POS_X;
      end else if (ay >= az) begin
         s2_m_in    = ay;
         s2_uc_in   = ex;
         s2_vc_in   = s1_y_ff[COORD_BITS-1] ? ez : -ez;
         s2_face_in = s1_y_ff[COORD_BITS-1] ? FACE_NEG_Y : FACE_POS_Y;
      end else begin
         s2_m_in    = az;
         s2_uc_in   = s1_z_ff[COORD_BITS-1] ? -ex : ex;
         s2_vc_in   = ey;
         s2_face_in = s1_z_ff[COORD_BITS-1] ? FACE_NEG_Z : FACE_POS_Z;
      end
   end

   always_comb begin
      s3_cu_in  = $unsigned(s2_uc_ff) + {1'b0, s2_m_ff};
      s3_cv_in  = $unsigned(s2_vc_ff) + {1'b0, s2_m_ff};
      s3_den_in = {s2_m_ff, 1'b0};
   end

   always_comb begin
      s4_in.valid = s3_valid_ff;
      s4_in.face  = s3_face_ff;
      s4_in.zero  = s3_zero_ff;
      s4_in.rem_u = NUM_BITS'(s3_cu_ff) * NUM_BITS'(scale_u);
      s4_in.rem_v = NUM_BITS'(s3_cv_ff) * NUM_BITS'(scale_v);
      s4_in.q_u   = '0;
      s4_in.q_v   = '0;
      s4_in.den   = s3_den_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff    <= dir_x;
         s1_y_ff    <= dir_y;
         s1_z_ff    <= dir_z;
         s2_face_ff <= s2_face_in;
         s2_zero_ff <= s2_zero_in;
         s2_uc_ff   <= s2_uc_in;
         s2_vc_ff   <= s2_vc_in;
         s2_m_ff    <= s2_m_in;
         s3_face_ff <= s2_face_ff;
         s3_zero_ff <= s2_zero_ff;
         s3_cu_ff   <= s3_cu_in;
         s3_cv_ff   <= s3_cv_in;
         s3_den_ff  <= s3_den_in;
         s4_ff.face  <= s4_in.face;
         s4_ff.zero  <= s4_in.zero;
         s4_ff.rem_u <= s4_in.rem_u;
         s4_ff.rem_v <= s4_in.rem_v;
         s4_ff.q_u   <= s4_in.q_u;
         s4_ff.q_v   <= s4_in.q_v;
         s4_ff.den   <= s4_in.den;
      end
   end

   assign out_stage = s4_ff;

endmodule

`default_nettype wire

[rtl/core/cmfs_div_pipe.sv]
// ----------------------------------------------------------------------------
// Cube map face select divider pipeline
// Restoring division of both dividends by the shared divisor, one quotient
// bit per register stage, most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module cmfs_div_pipe (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  cmfs_pkg::div_stage_type in_stage,
   output cmfs_pkg::div_stage_type out_stage
);
   import cmfs_pkg::*;

   div_stage_type stage_ff [IDX_BITS];
   div_stage_type stage_in [IDX_BITS];

   for (genvar k = 0; k < IDX_BITS; k++) begin : g_stage
      localparam int SHIFT = IDX_BITS - 1 - k;
      div_stage_type src;
      logic [NUM_BITS-1:0] trial;
      logic take_u, take_v;

      if (k == 0) begin : g_first
         assign src = in_stage;
      end else begin : g_next
         assign src = stage_ff[k-1];
      end

      always_comb begin
         trial  = NUM_BITS'(src.den) << SHIFT;
         take_u = src.rem_u >= trial;
         take_v = src.rem_v >= trial;
         stage_in[k]       = src;
         stage_in[k].rem_u = take_u ? src.rem_u - trial : src.rem_u;
         stage_in[k].rem_v = take_v ? src.rem_v - trial : src.rem_v;
         stage_in[k].q_u   = {src.q_u[IDX_BITS-2:0], take_u};
         stage_in[k].q_v   = {src.q_v[IDX_BITS-2:0], take_v};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else if (en) begin
            stage_ff[k].valid <= stage_in[k].valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stage_ff[k].face  <= stage_in[k].face;
            stage_ff[k].zero  <= stage_in[k].zero;
            stage_ff[k].rem_u <= stage_in[k].rem_u;
            stage_ff[k].rem_v <= stage_in[k].rem_v;
            stage_ff[k].q_u   <= stage_in[k].q_u;
            stage_ff[k].q_v   <= stage_in[k].q_v;
            stage_ff[k].den   <= stage_in[k].den;
         end
      end
   end

   assign out_stage = stage_ff[IDX_BITS-1];

endmodule

`default_nettype wire
